// ===== src/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared constants, types and helper functions for the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Default number of samples carried by one packet.
  localparam int SAMPLES_DEF = 8;

  // Framing bytes.
  localparam logic [7:0] SYNC_A   = 8'hAA;
  localparam logic [7:0] SYNC_B   = 8'h03;
  localparam logic [7:0] END_MARK = 8'h55;

  // Distance code that means no return.
  localparam logic [15:0] NO_RETURN = 16'h8000;

  // Angle constants: one turn in 1/64 degree and in 1/448 degree.
  localparam logic [15:0] TURN_64      = 16'd23040;
  localparam logic [15:0] TWO_TURN_64  = 16'd46080;
  localparam logic [15:0] HALF_TURN_64 = 16'd11520;
  localparam logic [18:0] TURN_448     = 19'd161280;

  // Field widths.
  localparam int ANGLE_W = 18;
  localparam int DIST_W  = 16;
  localparam int RAW_W   = 16;
  localparam int ANG64_W = 15;
  localparam int SKIP_W  = 6;

  // Fractional bits of the reciprocal used to divide by the sample gap count.
  localparam int RECIP_K = 18;

  // Status of the packet queue as seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Reduce a raw 16-bit angle to one turn in 1/64 degree.
  function automatic logic [ANG64_W-1:0] mod_turn(input logic [RAW_W-1:0] raw);
    logic [RAW_W-1:0] red;
    if (raw >= TWO_TURN_64) begin
      red = raw - TWO_TURN_64;
    end else if (raw >= TURN_64) begin
      red = raw - TURN_64;
    end else begin
      red = raw;
    end
    return red[ANG64_W-1:0];
  endfunction

endpackage

// ===== src/lpd_if.sv =====
// ----------------------------------------------------------------------------
// lpd_if
// Valid/ready stream interfaces for the serial byte input and sample output.
// ----------------------------------------------------------------------------

// Serial byte stream, one byte per beat.
interface lpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Sample stream, one sample per beat.
interface lpd_sample_if;
  logic        valid;
  logic        ready;
  logic [17:0] angle;
  logic [15:0] distance_mm;
  logic        distance_valid;
  logic        revolution_start;
  logic [2:0]  sample_index;
  logic        last;

  modport source (
    output valid, output angle, output distance_mm, output distance_valid,
    output revolution_start, output sample_index, output last, input ready
  );
  modport sink (
    input valid, input angle, input distance_mm, input distance_valid,
    input revolution_start, input sample_index, input last, output ready
  );
endinterface

// ===== src/lpd_front.sv =====
// ----------------------------------------------------------------------------
// lpd_front
// Byte window, frame detection and overlap skip; pushes found packets.
// ----------------------------------------------------------------------------
module lpd_front #(
  parameter int SAMPLES_PER_PACKET = lpd_pkg::SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  lpd_byte_if.sink                           rx,
  input  lpd_pkg::q_status_t                 q_stat,
  output logic                               push,
  output logic [16*SAMPLES_PER_PACKET+31:0]  push_data
);
  import lpd_pkg::*;

  localparam int PACKET_LEN = 3 * SAMPLES_PER_PACKET + 12;

  logic [7:0]        win [PACKET_LEN];
  logic [SKIP_W-1:0] skip;
  logic              take;
  logic              hit;

  // A byte is taken whenever the queue can hold one more packet.
  assign rx.ready = !q_stat.full;
  assign take     = rx.valid && rx.ready;

  // Frame test on the window as it stands after this byte shifts in.
  assign hit = (win[1] == SYNC_A) && (win[2] == SYNC_B) &&
               (win[3] == 8'(SAMPLES_PER_PACKET)) && (rx.rx_byte == END_MARK);

  assign push = take && (skip == '0) && hit;

  // Packet fields taken from the shifted window (offset one from win).
  assign push_data[15:0]  = {win[7], win[6]};
  assign push_data[31:16] = {win[3*SAMPLES_PER_PACKET+9], win[3*SAMPLES_PER_PACKET+8]};

  for (genvar i = 0; i < SAMPLES_PER_PACKET; i++) begin : g_dist
    assign push_data[32+16*i +: 16] = {win[3*i+9], win[3*i+8]};
  end

  // Window shift and skip of starts that fall inside the last packet.
  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= '0;
      for (int k = 0; k < PACKET_LEN; k++) begin
        win[k] <= '0;
      end
    end else if (take) begin
      for (int k = 0; k < PACKET_LEN - 1; k++) begin
        win[k] <= win[k+1];
      end
      win[PACKET_LEN-1] <= rx.rx_byte;
      if (skip != '0) begin
        skip <= skip - 1'b1;
      end else if (hit) begin
        skip <= SKIP_W'(PACKET_LEN - 1);
      end
    end
  end

endmodule

// ===== src/lpd_queue.sv =====
// ----------------------------------------------------------------------------
// lpd_queue
// Two-entry packet queue between the front and the back.
// ----------------------------------------------------------------------------
module lpd_queue #(
  parameter int WIDTH = 160
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output lpd_pkg::q_status_t q_stat,
  output logic [WIDTH-1:0]   head
);
  import lpd_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign head         = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== src/lpd_back.sv =====
// ----------------------------------------------------------------------------
// lpd_back
// Angle computation and sample emission for one queued packet at a time.
// ----------------------------------------------------------------------------
module lpd_back #(
  parameter int SAMPLES_PER_PACKET = lpd_pkg::SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  lpd_pkg::q_status_t                 q_stat,
  input  logic [16*SAMPLES_PER_PACKET+31:0]  head,
  output logic                               pop,
  lpd_sample_if.source                       tx
);
  import lpd_pkg::*;

  localparam int IDX_W = $clog2(SAMPLES_PER_PACKET);
  localparam int GAPS  = SAMPLES_PER_PACKET - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GAPS);
  localparam logic [IDX_W:0]   GAPS_N   = (IDX_W + 1)'(GAPS);
  localparam logic [ANGLE_W-1:0] GAPS_A = ANGLE_W'(GAPS);
  localparam logic [RECIP_K:0] RECIP    = (RECIP_K + 1)'((1 << RECIP_K) / GAPS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MOD, ST_SPAN, ST_SCALE, ST_MUL, ST_QEST, ST_FIX, ST_EMIT
  } state_t;

  state_t state;

  logic [DIST_W-1:0]            samp_dist [SAMPLES_PER_PACKET];
  logic [RAW_W-1:0]             raw_start;
  logic [RAW_W-1:0]             raw_end;
  logic [ANG64_W-1:0]           start_a;
  logic [ANG64_W-1:0]           end_a;
  logic [ANG64_W-1:0]           last_end;
  logic                         seen;
  logic                         rev;
  logic [ANG64_W-1:0]           span;
  logic [ANGLE_W-1:0]           span7;
  logic [ANGLE_W-1:0]           start7;
  logic [ANGLE_W+RECIP_K:0]     prod;
  logic [ANGLE_W-1:0]           q_est;
  logic [ANGLE_W-1:0]           step_q;
  logic [IDX_W-1:0]             step_r;
  logic [ANGLE_W-1:0]           acc_q;
  logic [IDX_W-1:0]             acc_r;
  logic [IDX_W-1:0]             idx;

  logic                         slot_free;
  logic [ANGLE_W:0]             ang_sum;
  logic [ANGLE_W-1:0]           ang_wrap;
  logic [IDX_W:0]               r_sum;
  logic [IDX_W+2:0]             idx_ext;
  logic [ANGLE_W-1:0]           r_diff;
  logic [ANGLE_W-1:0]           start_sel;
  logic [ANGLE_W-1:0]           span_sel;

  assign pop       = (state == ST_IDLE) && !q_stat.empty;
  assign slot_free = !tx.valid || tx.ready;

  // Angle of the current sample, wrapped at one turn.
  assign ang_sum  = {1'b0, start7} + {1'b0, acc_q};
  assign ang_wrap = (ang_sum >= TURN_448) ? ANGLE_W'(ang_sum - TURN_448)
                                          : ang_sum[ANGLE_W-1:0];

  // Remainder bookkeeping for the running interpolation step.
  assign r_sum   = {1'b0, acc_r} + {1'b0, step_r};
  assign idx_ext = {3'b000, idx};

  // Remainder of the reciprocal estimate, known to be below twice the gap count.
  assign r_diff = span7 - ANGLE_W'(q_est * GAPS_A);

  assign start_sel = {3'b000, start_a};
  assign span_sel  = {3'b000, span};

  // Sequencer and registered sample output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seen     <= 1'b0;
      last_end <= '0;
      tx.valid <= 1'b0;
    end else begin
      // A taken beat is dropped unless the next sample replaces it.
      if (tx.valid && tx.ready && (state != ST_EMIT)) begin
        tx.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            raw_start <= head[15:0];
            raw_end   <= head[31:16];
            for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
              samp_dist[i] <= head[32+16*i +: 16];
            end
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          start_a  <= mod_turn(raw_start);
          end_a    <= mod_turn(raw_end);
          state    <= ST_SPAN;
        end
        ST_SPAN: begin
          rev      <= seen && (({1'b0, start_a} + HALF_TURN_64) < {1'b0, last_end});
          last_end <= end_a;
          seen     <= 1'b1;
          if (end_a >= start_a) begin
            span <= end_a - start_a;
          end else begin
            span <= ANG64_W'({1'b0, end_a} + TURN_64 - {1'b0, start_a});
          end
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          span7  <= (span_sel << 3) - span_sel;
          start7 <= (start_sel << 3) - start_sel;
          state  <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= span7 * RECIP;
          state <= ST_QEST;
        end
        ST_QEST: begin
          q_est <= prod[RECIP_K +: ANGLE_W];
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (r_diff[IDX_W:0] >= GAPS_N) begin
            step_q <= q_est + 1'b1;
            step_r <= IDX_W'(r_diff[IDX_W:0] - GAPS_N);
          end else begin
            step_q <= q_est;
            step_r <= r_diff[IDX_W-1:0];
          end
          acc_q <= '0;
          acc_r <= '0;
          idx   <= '0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            tx.valid            <= 1'b1;
            tx.angle            <= ang_wrap;
            tx.distance_mm      <= samp_dist[idx];
            tx.distance_valid   <= (samp_dist[idx] != '0) && (samp_dist[idx] != NO_RETURN);
            tx.revolution_start <= rev && (idx == '0);
            tx.sample_index     <= idx_ext[2:0];
            tx.last             <= (idx == LAST_IDX);
            if (r_sum >= GAPS_N) begin
              acc_q <= acc_q + step_q + 1'b1;
              acc_r <= IDX_W'(r_sum - GAPS_N);
            end else begin
              acc_q <= acc_q + step_q;
              acc_r <= r_sum[IDX_W-1:0];
            end
            idx <= idx + 1'b1;
            if (idx == LAST_IDX) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lidar_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// lidar_packet_deframer
// Finds fixed-size lidar packets in a serial byte stream and emits samples.
// ----------------------------------------------------------------------------
// Usage: feed raw serial bytes on rx, one byte per beat. The block keeps a
// sliding window of 3*SAMPLES_PER_PACKET+12 bytes and recognizes a packet
// by its two sync bytes, sample count and end byte. For each packet it
// sends SAMPLES_PER_PACKET beats on samples, carrying distance, validity,
// interpolated angle, sample index, a revolution-start flag and last.
// Throughput: one byte per cycle in while the queue is not full. The back
// end works on one packet at a time: it loads the packet, does the angle
// setup (reduction, span, scaling, reciprocal multiply, quotient estimate,
// correction) and then emits the samples in order, each once the output
// register is free to take it.
// A two-packet queue lets bytes keep flowing while samples drain. When the
// sample receiver stalls, samples wait in the output register; once both
// queue slots are full, rx.ready drops until the back end takes a packet.
// Reset (synchronous, active high) clears the byte window, the skip count,
// the queue, the revolution tracking and any pending output.
// ----------------------------------------------------------------------------
module lidar_packet_deframer #(
  parameter int SAMPLES_PER_PACKET = lpd_pkg::SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lpd_byte_if.sink     rx,
  lpd_sample_if.source samples
);
  import lpd_pkg::*;

  localparam int ENTRY_W = 16 * SAMPLES_PER_PACKET + 32;

  q_status_t          q_stat;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] head;

  // Byte window and frame detection.
  lpd_front #(
    .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .q_stat   (q_stat),
    .push     (push),
    .push_data(push_data)
  );

  // Packet queue.
  lpd_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // Angle setup and sample emission.
  lpd_back #(
    .SAMPLES_PER_PACKET(SAMPLES_PER_PACKET)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .q_stat(q_stat),
    .head  (head),
    .pop   (pop),
    .tx    (samples)
  );

endmodule
